>>> design/egsv_pkg.sv
package egsv_pkg;

	localparam int WIDTH = 64;
	localparam int CW = $clog2(WIDTH);

	// Register indexes of the configuration port.
	localparam logic [1:0] CFG_MODULUS    = 2'd0;
	localparam logic [1:0] CFG_GENERATOR  = 2'd1;
	localparam logic [1:0] CFG_PUBLIC_KEY = 2'd2;

	localparam logic [WIDTH-1:0] MODULUS_RST    = WIDTH'(19);
	localparam logic [WIDTH-1:0] GENERATOR_RST  = WIDTH'(2);
	localparam logic [WIDTH-1:0] PUBLIC_KEY_RST = WIDTH'(18);

	typedef struct packed {
		logic [WIDTH-1:0] message;
		logic [WIDTH-1:0] sig_first;
		logic [WIDTH-1:0] sig_second;
	} egsv_in_t;

	typedef struct packed {
		logic             valid_res;
		logic [WIDTH-1:0] left_residue;
		logic [WIDTH-1:0] right_residue;
	} egsv_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_EBIT,
		S_MACC,
		S_MSQ,
		S_FIN,
		S_OUT
	} egsv_state_t;

	// Which of the three powers is being worked on.
	typedef enum logic [1:0] {
		PH_PUB,
		PH_SIG,
		PH_GEN
	} egsv_phase_t;

endpackage

>>> design/elgamal_signature_verify_unit.sv
// Per item: the public key, the first signature part and the generator are each reduced
// modulo p and raised by square-and-multiply over WIDTH exponent bits, with an extra multiply
// for each set bit; the first two powers are multiplied into the left residue, then output.
// With a modulus below two the block skips the powers and goes straight to the output register.
// One item at a time through one bit-serial modular multiplier that retires one multiplier
// bit per cycle; the next input is taken once the result of the last one is registered.
// Reset (arst_n low) restores modulus 19, generator 2, public key 18 and empties the block.
module elgamal_signature_verify_unit
	import egsv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  egsv_in_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output egsv_out_t        out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [WIDTH-1:0] cfg_data
);

	egsv_state_t state_q, state_d;
	egsv_phase_t phase_q;

	logic [WIDTH-1:0] modulus_q, generator_q, public_key_q;
	logic [WIDTH-1:0] p_q, s1_q, s2_q, msg_q;
	logic [WIDTH-1:0] acc_q, sq_q, e_q, t1_q, left_q;
	logic [WIDTH-1:0] mul_a_q, mul_b_q, mul_r_q;
	logic [CW-1:0]    cnt_q, ebit_q;
	logic             out_valid_q;
	egsv_out_t        out_q;

	logic             mul_done, ebit_last, p_small, out_free;
	logic [WIDTH+1:0] mul_t;
	logic [WIDTH+2:0] mul_d1, mul_d2;
	logic [WIDTH-1:0] mul_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q    <= MODULUS_RST;
			generator_q  <= GENERATOR_RST;
			public_key_q <= PUBLIC_KEY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODULUS:    modulus_q    <= cfg_data;
				CFG_GENERATOR:  generator_q  <= cfg_data;
				CFG_PUBLIC_KEY: public_key_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// One step of the shift-add multiplier: r = 2r + bit*a, reduced once from below 3p.
	always_comb begin
		mul_t  = {1'b0, mul_r_q, 1'b0} + (mul_b_q[WIDTH-1] ? {2'b00, mul_a_q} : '0);
		mul_d1 = {1'b0, mul_t} - {3'b000, p_q};
		mul_d2 = {1'b0, mul_t} - {2'b00, p_q, 1'b0};
		if (!mul_d2[WIDTH+2]) begin
			mul_next = mul_d2[WIDTH-1:0];
		end else if (!mul_d1[WIDTH+2]) begin
			mul_next = mul_d1[WIDTH-1:0];
		end else begin
			mul_next = mul_t[WIDTH-1:0];
		end
	end

	assign p_small   = (modulus_q[WIDTH-1:1] == '0);
	assign ebit_last = (ebit_q == CW'(WIDTH - 1));
	assign out_free  = !out_valid_q || out_ready;

	// Outputs of the controller.
	always_comb begin
		in_ready = (state_q == S_IDLE);
		mul_done = ((state_q == S_RED) || (state_q == S_MACC) || (state_q == S_MSQ) ||
			(state_q == S_FIN)) && (cnt_q == CW'(WIDTH - 1));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = p_small ? S_OUT : S_RED;
			S_RED:  if (mul_done) state_d = S_EBIT;
			S_EBIT: state_d = e_q[0] ? S_MACC : S_MSQ;
			S_MACC: if (mul_done) state_d = S_MSQ;
			S_MSQ: begin
				if (mul_done) begin
					if (!ebit_last) begin
						state_d = S_EBIT;
					end else begin
						unique case (phase_q)
							PH_PUB:  state_d = S_RED;
							PH_SIG:  state_d = S_FIN;
							PH_GEN:  state_d = S_OUT;
							default: state_d = S_IDLE;
						endcase
					end
				end
			end
			S_FIN:  if (mul_done) state_d = S_RED;
			S_OUT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencing of the exponentiations and the multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PUB;
			cnt_q       <= '0;
			ebit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			cnt_q <= mul_done ? '0 : cnt_q + CW'(1);
			unique case (state_q)
				S_IDLE: begin
					cnt_q   <= '0;
					phase_q <= PH_PUB;
				end
				S_EBIT: cnt_q <= '0;
				S_MSQ: begin
					if (mul_done) begin
						ebit_q <= ebit_q + CW'(1);
						if (ebit_last) begin
							if (phase_q == PH_PUB) phase_q <= PH_SIG;
							else if (phase_q == PH_SIG) phase_q <= PH_GEN;
						end
					end
				end
				S_OUT: begin
					if (out_free) out_valid_q <= 1'b1;
				end
				default: ;
			endcase
			if (state_q == S_RED && mul_done) ebit_q <= '0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		mul_r_q <= mul_next;
		mul_b_q <= {mul_b_q[WIDTH-2:0], 1'b0};
		unique case (state_q)
			S_IDLE: begin
				msg_q   <= in_data.message;
				s1_q    <= in_data.sig_first;
				s2_q    <= in_data.sig_second;
				p_q     <= modulus_q;
				left_q  <= '0;
				acc_q   <= '0;
				mul_a_q <= WIDTH'(1);
				mul_b_q <= public_key_q;
				mul_r_q <= '0;
			end
			S_RED: begin
				if (mul_done) begin
					sq_q  <= mul_next;
					acc_q <= WIDTH'(1);
					unique case (phase_q)
						PH_PUB:  e_q <= s1_q;
						PH_SIG:  e_q <= s2_q;
						default: e_q <= msg_q;
					endcase
				end
			end
			S_EBIT: begin
				mul_a_q <= e_q[0] ? acc_q : sq_q;
				mul_b_q <= sq_q;
				mul_r_q <= '0;
			end
			S_MACC: begin
				if (mul_done) begin
					acc_q   <= mul_next;
					mul_a_q <= sq_q;
					mul_b_q <= sq_q;
					mul_r_q <= '0;
				end
			end
			S_MSQ: begin
				if (mul_done) begin
					sq_q <= mul_next;
					e_q  <= {1'b0, e_q[WIDTH-1:1]};
					if (ebit_last) begin
						unique case (phase_q)
							PH_PUB: begin
								t1_q    <= acc_q;
								mul_a_q <= WIDTH'(1);
								mul_b_q <= s1_q;
								mul_r_q <= '0;
							end
							PH_SIG: begin
								mul_a_q <= t1_q;
								mul_b_q <= acc_q;
								mul_r_q <= '0;
							end
							default: ;
						endcase
					end
				end
			end
			S_FIN: begin
				if (mul_done) begin
					left_q  <= mul_next;
					mul_a_q <= WIDTH'(1);
					mul_b_q <= generator_q;
					mul_r_q <= '0;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_q.left_residue  <= left_q;
					out_q.right_residue <= acc_q;
					out_q.valid_res     <= (left_q == acc_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks on the sequencing.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block still ready after an input transfer");

	a_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.valid_res == (out_data.left_residue == out_data.right_residue)))
		else $error("match flag disagrees with residues");

	a_mul_needs_modulus: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED || state_q == S_MACC || state_q == S_MSQ || state_q == S_FIN)
		|-> (p_q[WIDTH-1:1] != '0))
		else $error("multiplier running with modulus below two");

endmodule
